>>> design/mmbd_pkg.sv
// Shared types and constants for the min/max bucket decimator.
// Used by the front, queue, back and top-level modules.

package mmbd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 24;
  localparam int TARGET_BITS   = 16;
  localparam int ACC_BITS      = COUNT_BITS + 16;
  localparam int CFG_DATA_BITS = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;
  localparam int CFG_IDX_BITS  = 1;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  // Smallest budget that enables decimation, and the two end points it reserves.
  localparam int MIN_TARGET    = 3;
  localparam int END_POINTS    = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SAMPLE_COUNT  = 1'b0,
    CFG_TARGET_POINTS = 1'b1
  } mmbd_cfg_idx_t;

  // One queue entry: one or two results caused by one sample.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] first_val;
    logic signed [SAMPLE_BITS-1:0] second_val;
    logic                          two;
    logic                          fin;
  } mmbd_entry_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic        valid;
    mmbd_entry_t entry;
  } mmbd_head_t;

endpackage

>>> design/min_max_bucket_decimator_unit.sv
// Min/max bucket decimator, top level.
// Connects the front end, result queue and back end. Uses mmbd_pkg.
//
// Usage:
//   Write sample_count (index 0) and target_points (index 1) on the cfg port
//   between series. Samples enter on in_* one per accepted request, in series
//   order. Each sample causes zero, one or two results on out_*; out_final_res
//   marks the last result of a series. With sample_count zero samples are
//   dropped without results.
// Timing:
//   A sample is taken every cycle while the queue has room. Its results pass
//   through the queue and then the output register. The back end delivers
//   one result per cycle while out_stall is low, so the min and max of one
//   bucket leave one after the other; the four-entry queue absorbs these bursts.
// Stall:
//   out_stall holds the output register; the queue fills and then in_stall
//   rises until the receiver takes results again. Nothing is dropped.
// Reset:
//   rst_n (synchronous) clears configuration to zero, the series position,
//   the queue and the output valid; the first sample after reset starts a series.

module min_max_bucket_decimator_unit
  import mmbd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_final_res
);

  logic        push;
  mmbd_entry_t push_entry;
  logic        q_full;
  logic        pop;
  mmbd_head_t  head;

  mmbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mmbd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  mmbd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_final_res (out_final_res)
  );

endmodule

>>> design/mmbd_front.sv
// Front end: holds configuration, tracks series position and bucket min/max,
// and pushes the results of each accepted sample into the queue. Uses mmbd_pkg.

module mmbd_front
  import mmbd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          q_full,
  output logic                          push,
  output mmbd_entry_t                   push_entry
);

  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic [TARGET_BITS-1:0]        target_r, target_nxt;
  logic [COUNT_BITS-1:0]         idx_r, idx_nxt;
  logic [ACC_BITS-1:0]           pos_r, pos_nxt;
  logic [ACC_BITS-1:0]           bound_r, bound_nxt;
  logic signed [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic signed [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [COUNT_BITS-1:0]         lpos_r, lpos_nxt;
  logic [COUNT_BITS-1:0]         hpos_r, hpos_nxt;
  logic                          open_r, open_nxt;

  logic                          accept;
  logic [COUNT_BITS:0]           idx_inc;
  logic                          last;
  logic                          pass_through;
  logic [TARGET_BITS-1:0]        buckets_raw;
  logic [TARGET_BITS-1:0]        buckets;
  logic [ACC_BITS-1:0]           span;
  logic                          crossing;
  logic signed [SAMPLE_BITS-1:0] low_upd, high_upd;
  logic [COUNT_BITS-1:0]         lpos_upd, hpos_upd;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign idx_inc      = {1'b0, idx_r} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign last         = idx_inc >= {1'b0, count_r};
  assign pass_through = (CFG_DATA_BITS'(count_r) <= CFG_DATA_BITS'(target_r)) ||
                        (target_r < TARGET_BITS'(MIN_TARGET));
  assign buckets_raw  = (target_r - TARGET_BITS'(END_POINTS)) >> 1;
  assign buckets      = (buckets_raw == '0) ? TARGET_BITS'(1) : buckets_raw;
  assign span         = ACC_BITS'(count_r) - ACC_BITS'(END_POINTS);
  assign crossing     = pos_r > bound_r;

  // Running min/max including the current sample; first occurrence wins ties.
  always_comb begin
    low_upd  = low_r;
    high_upd = high_r;
    lpos_upd = lpos_r;
    hpos_upd = hpos_r;
    if (!open_r) begin
      low_upd  = in_sample;
      high_upd = in_sample;
      lpos_upd = idx_r;
      hpos_upd = idx_r;
    end else begin
      if (in_sample < low_r) begin
        low_upd  = in_sample;
        lpos_upd = idx_r;
      end
      if (in_sample > high_r) begin
        high_upd = in_sample;
        hpos_upd = idx_r;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    target_nxt = target_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT:  count_nxt  = cfg_wdata[COUNT_BITS-1:0];
        CFG_TARGET_POINTS: target_nxt = cfg_wdata[TARGET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    bound_nxt  = bound_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    lpos_nxt   = lpos_r;
    hpos_nxt   = hpos_r;
    open_nxt   = open_r;
    push       = 1'b0;
    push_entry = '{first_val: in_sample, second_val: in_sample, two: 1'b0, fin: 1'b0};

    if (accept && (count_r != '0)) begin
      if (pass_through || last) begin
        push           = 1'b1;
        push_entry.fin = last;
        if (last) begin
          idx_nxt  = '0;
          open_nxt = 1'b0;
        end else begin
          idx_nxt = idx_inc[COUNT_BITS-1:0];
        end
      end else if (idx_r == '0) begin
        // First sample: emit it and arm the accumulators.
        push      = 1'b1;
        pos_nxt   = ACC_BITS'({buckets, 1'b0});
        bound_nxt = span;
        open_nxt  = 1'b0;
        idx_nxt   = idx_inc[COUNT_BITS-1:0];
      end else begin
        low_nxt  = low_upd;
        high_nxt = high_upd;
        lpos_nxt = lpos_upd;
        hpos_nxt = hpos_upd;
        open_nxt = 1'b1;
        if (crossing) begin
          // Close the bucket: emit min and max in order of occurrence.
          push = 1'b1;
          if (lpos_upd <= hpos_upd) begin
            push_entry.first_val  = low_upd;
            push_entry.second_val = high_upd;
            push_entry.two        = (hpos_upd != lpos_upd);
          end else begin
            push_entry.first_val  = high_upd;
            push_entry.second_val = low_upd;
            push_entry.two        = 1'b1;
          end
          open_nxt  = 1'b0;
          bound_nxt = bound_r + span;
        end
        pos_nxt = pos_r + ACC_BITS'(buckets);
        idx_nxt = idx_inc[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      target_r <= '0;
      idx_r    <= '0;
      pos_r    <= '0;
      bound_r  <= '0;
      low_r    <= '0;
      high_r   <= '0;
      lpos_r   <= '0;
      hpos_r   <= '0;
      open_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      bound_r  <= bound_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      lpos_r   <= lpos_nxt;
      hpos_r   <= hpos_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

>>> design/mmbd_fifo.sv
// Short queue of result entries between the front and back ends.
// Uses mmbd_pkg for the entry type and depth.

module mmbd_fifo
  import mmbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mmbd_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output mmbd_head_t  head
);

  mmbd_entry_t         mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                empty;

  assign full       = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty      = count_r == '0;
  assign head.valid = !empty;
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && !full) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> design/mmbd_back.sv
// Back end: takes entries from the queue and sends their one or two results
// through the output register. Uses mmbd_pkg.

module mmbd_back
  import mmbd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmbd_head_t                    head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_final_res
);

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_value_r, out_value_nxt;
  logic                          out_fin_r, out_fin_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] pend_value_r, pend_value_nxt;
  logic                          pend_fin_r, pend_fin_nxt;
  logic                          load;

  assign load          = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_final_res = out_fin_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_fin_nxt    = out_fin_r;
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    pend_fin_nxt   = pend_fin_r;
    pop            = 1'b0;
    if (load) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = pend_value_r;
        out_fin_nxt    = pend_fin_r;
        pend_valid_nxt = 1'b0;
      end else if (head.valid) begin
        // Hold the second value of a pair until the first is taken.
        pop            = 1'b1;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = head.entry.first_val;
        out_fin_nxt    = head.entry.fin && !head.entry.two;
        pend_valid_nxt = head.entry.two;
        pend_value_nxt = head.entry.second_val;
        pend_fin_nxt   = head.entry.fin;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_fin_r    <= out_fin_nxt;
    pend_value_r <= pend_value_nxt;
    pend_fin_r   <= pend_fin_nxt;
  end

`ifndef SYNTH
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r) else $error("pending result without shown result");
  a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (load && !pend_valid_r)) else $error("pop while output busy");
  a_final_not_split: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> !pend_valid_r) else $error("final flag before pair end");
`endif

endmodule
